FILE: rtl/rvc_pkg.sv
// shared opcodes, function codes and result beat layout for the rv32i subset core
package rvc_pkg;

  localparam logic [6:0] OpcOp     = 7'h33;
  localparam logic [6:0] OpcOpImm  = 7'h13;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcJal    = 7'h6F;
  localparam logic [6:0] OpcJalr   = 7'h67;

  localparam logic [2:0] F3AddSub = 3'd0;
  localparam logic [2:0] F3Sll    = 3'd1;
  localparam logic [2:0] F3Slt    = 3'd2;
  localparam logic [2:0] F3Xor    = 3'd4;
  localparam logic [2:0] F3Shr    = 3'd5;
  localparam logic [2:0] F3Or     = 3'd6;
  localparam logic [2:0] F3And    = 3'd7;
  localparam logic [2:0] F3Word   = 3'd2;
  localparam logic [2:0] F3Beq    = 3'd0;
  localparam logic [2:0] F3Bne    = 3'd1;
  localparam logic [2:0] F3Blt    = 3'd4;
  localparam logic [2:0] F3Bge    = 3'd5;
  localparam logic [2:0] F3Jalr   = 3'd0;

  localparam logic [6:0] F7Base = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;

  localparam logic [31:0] HaltLimit = 32'hFFFF_FFFB;

  localparam int OutBits  = 169;
  localparam int OutBytes = (OutBits + 7) / 8;
  localparam int OutWidth = OutBytes * 8;

  typedef struct packed {
    logic        illegal;
    logic        halted;
    logic [31:0] mem_data;
    logic [31:0] mem_address;
    logic        mem_write;
    logic [31:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_write;
    logic [31:0] next_pc;
    logic [31:0] exec_pc;
  } out_beat_t;

endpackage

FILE: rtl/rv32i_subset_core.sv
// rv32i subset core: register file and data store in rams, one execute stage
// an accepted instruction is registered in ins_q, and its result beat is registered in out_q
// one instruction per cycle unless the output stalls; lw waits for its data store read
// after reset the data store is swept to zero, one word a cycle over all DATA_WORDS words,
// with s_axis_tready low; pc, register valid bits and handshake state clear at once
// register file reads are issued at accept, the last write is forwarded
module rv32i_subset_core import rvc_pkg::*; #(
  parameter int DATA_WORDS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // instr[31:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // exec_pc[31:0] next_pc[63:32] reg_write[64] reg_index[69:65] reg_value[101:70]
  // mem_write[102] mem_address[134:103] mem_data[166:135] halted[167] illegal[168]
  output logic [OutWidth-1:0] m_axis_tdata
);

  localparam int AW = $clog2(DATA_WORDS);

  // handshake and stage state
  logic        in_fire;
  logic        ex_valid_q, ex_valid_d;
  logic [31:0] ins_q;
  logic        ld_wait_q, ld_wait_d;
  logic        ex_done, ld_issue, out_free;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q;
  out_beat_t   beat;
  logic [31:0] pc_q;

  // register file
  logic [31:0] rf_valid_q;
  logic        fw_en_q;
  logic [4:0]  fw_idx_q;
  logic [31:0] fw_val_q;
  logic [31:0] rf1_rdata, rf2_rdata;
  logic        rf_we;

  // data store clear pass
  logic          clearing_q;
  logic [AW-1:0] clr_idx_q;
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;
  logic [31:0]   dm_rdata;
  logic [AW-1:0] widx;
  logic [29:0]   word;

  // decode
  logic [6:0]  opc;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] a, b;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [4:0]  sh;
  logic        is_load;
  logic        wr, mw, halt, bad;
  logic [31:0] val, maddr, mdata, npc;
  logic        take;

  assign in_fire = s_axis_tvalid & s_axis_tready;
  assign out_free = ~out_valid_q | m_axis_tready;

  assign opc = ins_q[6:0];
  assign rd  = ins_q[11:7];
  assign f3  = ins_q[14:12];
  assign rs1 = ins_q[19:15];
  assign rs2 = ins_q[24:20];
  assign f7  = ins_q[31:25];

  always_comb begin
    if (rs1 == 5'd0) begin
      a = '0;
    end else if (fw_en_q && fw_idx_q == rs1) begin
      a = fw_val_q;
    end else if (rf_valid_q[rs1]) begin
      a = rf1_rdata;
    end else begin
      a = '0;
    end
    if (rs2 == 5'd0) begin
      b = '0;
    end else if (fw_en_q && fw_idx_q == rs2) begin
      b = fw_val_q;
    end else if (rf_valid_q[rs2]) begin
      b = rf2_rdata;
    end else begin
      b = '0;
    end
  end

  assign imm_i = {{20{ins_q[31]}}, ins_q[31:20]};
  assign imm_s = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
  assign imm_b = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
  assign imm_u = {ins_q[31:12], 12'h000};
  assign imm_j = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};
  assign sh    = b[4:0];

  assign halt    = ins_q >= HaltLimit;
  assign is_load = ~halt && opc == OpcLoad && f3 == F3Word;
  assign maddr   = is_load ? a + imm_i : a + imm_s;
  assign word    = maddr[31:2] % 30'(DATA_WORDS);
  assign widx    = AW'(word);

  always_comb begin
    wr    = 1'b0;
    mw    = 1'b0;
    bad   = 1'b0;
    val   = '0;
    mdata = '0;
    take  = 1'b0;
    npc   = pc_q + 32'd4;
    if (halt) begin
      npc = pc_q;
    end else begin
      unique case (opc)
        OpcOp: begin
          wr = 1'b1;
          if (f7 == F7Base) begin
            unique case (f3)
              F3AddSub: val = a + b;
              F3Sll:    val = a << sh;
              F3Slt:    val = {31'd0, $signed(a) < $signed(b)};
              F3Xor:    val = a ^ b;
              F3Shr:    val = a >> sh;
              F3Or:     val = a | b;
              F3And:    val = a & b;
              default:  bad = 1'b1;
            endcase
          end else if (f7 == F7Alt && f3 == F3AddSub) begin
            val = a - b;
          end else if (f7 == F7Alt && f3 == F3Shr) begin
            val = 32'($signed(a) >>> sh);
          end else begin
            bad = 1'b1;
          end
        end
        OpcOpImm: begin
          wr = 1'b1;
          unique case (f3)
            F3AddSub: val = a + imm_i;
            F3Or:     val = a | imm_i;
            F3And:    val = a & imm_i;
            default:  bad = 1'b1;
          endcase
        end
        OpcLoad: begin
          if (f3 == F3Word) begin
            wr    = 1'b1;
            mdata = dm_rdata;
            val   = dm_rdata;
          end else begin
            bad = 1'b1;
          end
        end
        OpcStore: begin
          if (f3 == F3Word) begin
            mw    = 1'b1;
            mdata = b;
          end else begin
            bad = 1'b1;
          end
        end
        OpcBranch: begin
          unique case (f3)
            F3Beq:   take = a == b;
            F3Bne:   take = a != b;
            F3Blt:   take = $signed(a) < $signed(b);
            F3Bge:   take = !($signed(a) < $signed(b));
            default: bad = 1'b1;
          endcase
          if (take) begin
            npc = pc_q + imm_b;
          end
        end
        OpcLui: begin
          wr  = 1'b1;
          val = imm_u;
        end
        OpcAuipc: begin
          wr  = 1'b1;
          val = pc_q + imm_u;
        end
        OpcJal: begin
          wr  = 1'b1;
          val = pc_q + 32'd4;
          npc = pc_q + imm_j;
        end
        OpcJalr: begin
          if (f3 == F3Jalr) begin
            wr  = 1'b1;
            val = pc_q + 32'd4;
            npc = (a + imm_i) & ~32'd1;
          end else begin
            bad = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        wr    = 1'b0;
        mw    = 1'b0;
        val   = '0;
        mdata = '0;
        npc   = pc_q + 32'd4;
      end
    end
    if (rd == 5'd0) begin
      wr = 1'b0;
    end
    if (!wr) begin
      val = '0;
    end
  end

  always_comb begin
    beat.exec_pc     = pc_q;
    beat.next_pc     = npc;
    beat.reg_write   = wr;
    beat.reg_index   = wr ? rd : 5'd0;
    beat.reg_value   = val;
    beat.mem_write   = mw;
    beat.mem_address = (is_load || mw) ? maddr : 32'd0;
    beat.mem_data    = mdata;
    beat.halted      = halt;
    beat.illegal     = bad;
  end

  // a load first issues a data store read, then completes once the read data is registered and the output is free
  assign ld_issue = ex_valid_q & is_load & ~ld_wait_q;
  assign ex_done  = ex_valid_q & out_free & (~is_load | ld_wait_q);
  assign ld_wait_d = ld_issue ? 1'b1 : (ex_done ? 1'b0 : ld_wait_q);

  assign s_axis_tready = ~clearing_q & (~ex_valid_q | ex_done);
  assign ex_valid_d    = in_fire | (ex_valid_q & ~ex_done);
  assign out_valid_d   = ex_done | (out_valid_q & ~m_axis_tready);

  assign rf_we = ex_done & wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      ld_wait_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      rf_valid_q  <= '0;
      fw_en_q     <= 1'b0;
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      ld_wait_q   <= ld_wait_d;
      out_valid_q <= out_valid_d;
      if (ex_done) begin
        pc_q <= npc;
      end
      if (rf_we) begin
        rf_valid_q[rd] <= 1'b1;
        fw_en_q        <= 1'b1;
      end
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + AW'(1);
        if (clr_idx_q == AW'(DATA_WORDS - 1)) begin
          clearing_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ins_q <= s_axis_tdata;
    end
    if (ex_done) begin
      out_q <= beat;
    end
    if (rf_we) begin
      fw_idx_q <= rd;
      fw_val_q <= val;
    end
  end

  rvc_ram #(.Width(32), .Depth(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rd),
    .wdata_i (val),
    .re_i    (in_fire),
    .raddr_i (s_axis_tdata[19:15]),
    .rdata_o (rf1_rdata)
  );

  rvc_ram #(.Width(32), .Depth(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rd),
    .wdata_i (val),
    .re_i    (in_fire),
    .raddr_i (s_axis_tdata[24:20]),
    .rdata_o (rf2_rdata)
  );

  assign dm_we    = clearing_q | (ex_done & mw);
  assign dm_waddr = clearing_q ? clr_idx_q : widx;
  assign dm_wdata = clearing_q ? 32'd0 : b;

  rvc_ram #(.Width(32), .Depth(DATA_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .re_i    (ld_issue),
    .raddr_i (widx),
    .rdata_o (dm_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutWidth - OutBits){1'b0}}, out_q};

endmodule

FILE: rtl/rvc_ram.sv
// generic simple dual-port ram with registered read
module rvc_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rvc_checker.sv
// port-level checks for the rv32i subset core, bound to the top level
module rvc_checker import rvc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutWidth-1:0] m_axis_tdata
);

  out_beat_t ob;
  assign ob = m_axis_tdata[OutBits-1:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ob.reg_write |-> ob.reg_index != 5'd0)
    else $error("write reported to x0");

  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ob.halted |-> ob.next_pc == ob.exec_pc && !ob.reg_write && !ob.mem_write)
    else $error("halt changed state");

  a_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ob.illegal |->
      !ob.reg_write && !ob.mem_write && ob.next_pc == ob.exec_pc + 32'd4)
    else $error("illegal instruction had an effect");

endmodule

bind rv32i_subset_core rvc_checker u_rvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
